### hdl/nnis_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nnis_pkg : shared types and constants of the nearest neighbor scaler
// Field widths, register codes, command and result records.
// ---------------------------------------------------------------------------
package nnis_pkg;

    // image limits and pixel packing
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PIXEL_BYTES = 4;

    // field widths
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 9;
    localparam int STEP_W  = 25;
    localparam int DST_W   = 12;
    localparam int CRD_W   = 8;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = DST_W + STEP_W;
    localparam int SRC_W   = PROD_W - FRAC_W;
    localparam int AREA_W  = 2 * SIZE_W;

    localparam int STORE_DEPTH = 65536;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [PIX_W-1:0] PIX_MASK = 32'hFFFF_FFFF >> (32 - 8 * PIXEL_BYTES);

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 8'd3;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] width;   // already clamped to 1..MAX
        logic [SIZE_W-1:0] height;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
    } t_cfg;

    typedef struct packed {
        logic              is_fetch;
        logic              wr_ok;    // load lies inside the image
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic [CRD_W-1:0]  col;
        logic [CRD_W-1:0]  row;
        logic              sat;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
        logic             sat;
    } t_res;

    typedef struct packed {
        logic nempty;
        logic full;
    } t_q_stat;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            r = SIZE_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/nnis_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nnis_ram : generic single port RAM
// One access a cycle, write or read, read data registered.
// ---------------------------------------------------------------------------
module nnis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nnis_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nnis_front : request intake and address mapping
// Three stage pipeline: scale products, clamp, raster address.
// Holds a credit count so the queue behind it never overflows.
// ---------------------------------------------------------------------------
module nnis_front #(
    parameter int QDEPTH = nnis_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nnis_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [nnis_pkg::ADDR_W-1:0]    i_load_index,
    input  logic [nnis_pkg::PIX_W-1:0]     i_load_pixel,
    input  logic [nnis_pkg::DST_W-1:0]     i_dst_x,
    input  logic [nnis_pkg::DST_W-1:0]     i_dst_y,
    output logic                           o_push,
    output nnis_pkg::t_cmd                 o_cmd,
    input  logic                           i_pop
);
    import nnis_pkg::*;

    localparam int USED_W = $clog2(QDEPTH + 1);

    logic [USED_W-1:0] r_used, n_used;
    logic              accept;

    // stage 1
    logic              r1_valid;
    logic              r1_fetch;
    logic [ADDR_W-1:0] r1_index;
    logic [PIX_W-1:0]  r1_data;
    logic [PROD_W-1:0] r1_prod_x, r1_prod_y;
    // stage 2
    logic              r2_valid;
    logic              r2_fetch;
    logic              r2_wr_ok;
    logic [ADDR_W-1:0] r2_index;
    logic [PIX_W-1:0]  r2_data;
    logic [SIZE_W-1:0] r2_sx, r2_sy;
    logic              r2_sat;
    // stage 3
    logic              r3_valid;
    t_cmd              r3_cmd;

    logic [AREA_W-1:0] r_area;

    logic [SRC_W-1:0]  src_x, src_y;
    logic [SIZE_W-1:0] lim_x, lim_y;
    logic              over_x, over_y;
    logic [SIZE_W-1:0] sx, sy;
    logic [ADDR_W-1:0] fetch_addr;

    // items in the pipeline plus items in the queue
    assign o_stall = (r_used >= USED_W'(QDEPTH));
    assign accept  = i_valid && !o_stall;
    assign n_used  = r_used + USED_W'(accept) - USED_W'(i_pop);

    assign src_x  = r1_prod_x[PROD_W-1:FRAC_W];
    assign src_y  = r1_prod_y[PROD_W-1:FRAC_W];
    assign lim_x  = i_cfg.width - SIZE_W'(1);
    assign lim_y  = i_cfg.height - SIZE_W'(1);
    assign over_x = (src_x > SRC_W'(lim_x));
    assign over_y = (src_y > SRC_W'(lim_y));
    assign sx     = over_x ? lim_x : src_x[SIZE_W-1:0];
    assign sy     = over_y ? lim_y : src_y[SIZE_W-1:0];

    assign fetch_addr = ADDR_W'(AREA_W'(r2_sy) * AREA_W'(i_cfg.width) + AREA_W'(r2_sx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r_used   <= n_used;
            r1_valid <= accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area    <= AREA_W'(i_cfg.width) * AREA_W'(i_cfg.height);

        r1_fetch  <= (i_req_type == REQ_FETCH);
        r1_index  <= i_load_index;
        r1_data   <= i_load_pixel & PIX_MASK;
        r1_prod_x <= PROD_W'(i_dst_x) * PROD_W'(i_cfg.step_x);
        r1_prod_y <= PROD_W'(i_dst_y) * PROD_W'(i_cfg.step_y);

        r2_fetch  <= r1_fetch;
        r2_wr_ok  <= (AREA_W'(r1_index) < r_area);
        r2_index  <= r1_index;
        r2_data   <= r1_data;
        r2_sx     <= sx;
        r2_sy     <= sy;
        r2_sat    <= over_x || over_y;

        r3_cmd.is_fetch <= r2_fetch;
        r3_cmd.wr_ok    <= r2_wr_ok;
        r3_cmd.addr     <= r2_fetch ? fetch_addr : r2_index;
        r3_cmd.data     <= r2_data;
        r3_cmd.col      <= r2_sx[CRD_W-1:0];
        r3_cmd.row      <= r2_sy[CRD_W-1:0];
        r3_cmd.sat      <= r2_sat;
    end

    assign o_push = r3_valid;
    assign o_cmd  = r3_cmd;

endmodule

### hdl/nnis_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nnis_queue : command queue between front and back
// Register based circular buffer, head visible without a read cycle.
// ---------------------------------------------------------------------------
module nnis_queue #(
    parameter int DEPTH = nnis_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nnis_pkg::t_cmd    i_data,
    input  logic              i_pop,
    output nnis_pkg::t_cmd    o_head,
    output nnis_pkg::t_q_stat o_stat
);
    import nnis_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign n_wr  = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd  = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
    assign n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head        = r_mem[r_rd];
    assign o_stat.nempty = (r_cnt != '0);
    assign o_stat.full   = (r_cnt == CNT_W'(DEPTH));

endmodule

### hdl/nnis_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nnis_back : frame store access and result buffer
// Writes loads that lie inside the image, reads fetches, buffers results in a two entry skid.
// ---------------------------------------------------------------------------
module nnis_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nnis_pkg::t_cmd    i_head,
    input  nnis_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output nnis_pkg::t_res    o_res
);
    import nnis_pkg::*;

    localparam int OB_DEPTH = 2;
    localparam int OB_CNT_W = 2;
    localparam int SLOT_W   = 3;

    t_res                r_ob [OB_DEPTH];
    logic [OB_CNT_W-1:0] r_ob_cnt;
    logic                r_ob_rd, r_ob_wr;

    logic              r_b2_valid;
    logic [CRD_W-1:0]  r_b2_col, r_b2_row;
    logic              r_b2_sat;

    logic [PIX_W-1:0]  rdata;
    logic              pop_out, push_out, credit_ok, issue;
    logic [SLOT_W-1:0] slots;
    t_res              push_res;

    assign o_valid  = (r_ob_cnt != '0);
    assign pop_out  = o_valid && !i_stall;
    assign push_out = r_b2_valid;

    // room for one more read after the one already in flight
    assign slots     = SLOT_W'(r_ob_cnt) + SLOT_W'(r_b2_valid) - SLOT_W'(pop_out)
                       + SLOT_W'(1);
    assign credit_ok = (slots <= SLOT_W'(OB_DEPTH));
    assign issue     = i_q_stat.nempty && (!i_head.is_fetch || credit_ok);
    assign o_pop     = issue;

    nnis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (issue && !i_head.is_fetch && i_head.wr_ok),
        .i_re    (issue && i_head.is_fetch),
        .i_addr  (i_head.addr),
        .i_wdata (i_head.data),
        .o_rdata (rdata)
    );

    assign push_res.pixel = rdata;
    assign push_res.col   = r_b2_col;
    assign push_res.row   = r_b2_row;
    assign push_res.sat   = r_b2_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
            r_ob_cnt   <= '0;
            r_ob_rd    <= 1'b0;
            r_ob_wr    <= 1'b0;
        end else begin
            r_b2_valid <= issue && i_head.is_fetch;
            r_ob_cnt   <= r_ob_cnt + OB_CNT_W'(push_out) - OB_CNT_W'(pop_out);
            if (push_out) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (pop_out) begin
                r_ob_rd <= ~r_ob_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b2_col <= i_head.col;
            r_b2_row <= i_head.row;
            r_b2_sat <= i_head.sat;
        end
        if (push_out) begin
            r_ob[r_ob_wr] <= push_res;
        end
    end

    assign o_res = r_ob[r_ob_rd];

endmodule

### hdl/nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_neighbor_image_scaler : nearest neighbor scaler with frame store
// Loads write source pixels into a 64K word store; fetches map a
// destination coordinate through 9.16 steps and return the source pixel.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  -------   ---  ----------------------  ----------------------------------
//  request   in   i_valid / o_stall       req_type load_index load_pixel
//                                         dst_x dst_y
//  result    out  o_valid / i_stall       pixel src_col src_row clamped
//  config    in   i_cfg_valid/o_cfg_ready cfg_index cfg_data
//
//  One request a cycle while o_stall is low, loads and fetches mixed freely.
//  A fetch passes three mapping stages (scale multiply, clamp,
//  row*width+col multiply), the queue, the store read and the result
//  buffer before its result is offered.
//  Loads give no result and are written to the store in request order.
//  o_stall rises when the command queue credits (QUEUE_DEPTH) are used up;
//  the store only issues a read while the two entry result buffer has room.
//  Reset is synchronous, active low; the store itself is not cleared.
//
module nearest_neighbor_image_scaler #(
    parameter int QUEUE_DEPTH = nnis_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [nnis_pkg::ADDR_W-1:0]       i_load_index,
    input  logic [nnis_pkg::PIX_W-1:0]        i_load_pixel,
    input  logic [nnis_pkg::DST_W-1:0]        i_dst_x,
    input  logic [nnis_pkg::DST_W-1:0]        i_dst_y,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [nnis_pkg::PIX_W-1:0]        o_pixel,
    output logic [nnis_pkg::CRD_W-1:0]        o_src_col,
    output logic [nnis_pkg::CRD_W-1:0]        o_src_row,
    output logic                              o_clamped,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nnis_pkg::*;

    // configuration registers, raw as written
    logic [SIZE_W-1:0] r_src_width;
    logic [SIZE_W-1:0] r_src_height;
    logic [STEP_W-1:0] r_step_x;
    logic [STEP_W-1:0] r_step_y;
    logic              cfg_wr;

    t_cfg    cfg;
    logic    q_push, q_pop;
    t_cmd    q_in, q_head;
    t_q_stat q_stat;
    t_res    res;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SIZE_W'(256);
            r_src_height <= SIZE_W'(256);
            r_step_x     <= STEP_W'(65536);
            r_step_y     <= STEP_W'(65536);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SIZE_W-1:0];
                CFG_STEP_X:     r_step_x     <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:     r_step_y     <= i_cfg_data[STEP_W-1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // zero size acts as one, oversize as the maximum
    assign cfg.width  = clamp_size(r_src_width, MAX_WIDTH);
    assign cfg.height = clamp_size(r_src_height, MAX_HEIGHT);
    assign cfg.step_x = r_step_x;
    assign cfg.step_y = r_step_y;

    // front: accept, map coordinates, bound-check loads
    nnis_front #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_load_index (i_load_index),
        .i_load_pixel (i_load_pixel),
        .i_dst_x      (i_dst_x),
        .i_dst_y      (i_dst_y),
        .o_push       (q_push),
        .o_cmd        (q_in),
        .i_pop        (q_pop)
    );

    // decoupling queue
    nnis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // back: frame store and result buffer
    nnis_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (res)
    );

    assign o_pixel   = res.pixel;
    assign o_src_col = res.col;
    assign o_src_row = res.row;
    assign o_clamped = res.sat;

    // ---- assertions ----

    // no result is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // front credits must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && q_stat.full) |-> q_pop)
        else $error("command queue overflow");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.nempty)
        else $error("command queue underflow");

endmodule
